// ===== sv/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, constants and codes of the first-fit block allocator.
// Block starts, header size and alignment are all multiples of the 8-byte
// grain, so the header store keeps one entry per grain.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HEAP_BYTES   = 8192;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;     // power of two, multiple of the grain

  localparam int GRAIN_SH = 3;
  localparam int POS_W    = $clog2(HEAP_BYTES);
  localparam int IDX_W    = POS_W - GRAIN_SH;
  localparam int ENTRIES  = HEAP_BYTES >> GRAIN_SH;
  localparam int REQ_W    = 16;
  localparam int OFF_W    = 13;
  localparam int STAT_W   = 2;
  localparam int NEED_W   = REQ_W + 1;
  localparam int CMP_W    = NEED_W + 2;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [NEED_W-1:0] need_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [OFF_W-1:0]  off_t;

  typedef struct packed {
    logic free_mark;
    pos_t size;
  } hdr_t;

  localparam hdr_t HDR_RESET = '{free_mark: 1'b1, size: pos_t'(HEAP_BYTES - HEADER_BYTES)};

  typedef struct packed {
    logic wr_en;
    idx_t wr_idx;
    hdr_t wr_data;
    logic rd_en;
    idx_t rd_idx;
  } mem_req_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOC   = 2'd0,
    ST_FREED   = 2'd1,
    ST_IGNORED = 2'd2,
    ST_NOMEM   = 2'd3
  } status_t;

endpackage

// ===== sv/ffba_hdr_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_hdr_store
// Block header memory, one write and one registered read port. Entry zero
// reads as the whole-heap free block until it is first written.
// ----------------------------------------------------------------------------
module ffba_hdr_store (
  input  logic              clk,
  input  logic              rst,
  input  ffba_pkg::mem_req_t req,
  output ffba_pkg::hdr_t    rd_data
);

  ffba_pkg::hdr_t mem [ffba_pkg::ENTRIES];
  ffba_pkg::hdr_t mem_q;
  logic           fresh;
  logic           rd_zero;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q   <= mem[req.rd_idx];
      rd_zero <= (req.rd_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
    end else if (req.wr_en && (req.wr_idx == '0)) begin
      fresh <= 1'b0;
    end
  end

  assign rd_data = (fresh && rd_zero) ? ffba_pkg::HDR_RESET : mem_q;

endmodule

// ===== sv/ffba_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_walk
// Request sequencer with the header arithmetic: walks block headers one
// per cycle, splits and marks on allocate, sets the free mark on free.
// ----------------------------------------------------------------------------
module ffba_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          op,
  input  logic [ffba_pkg::REQ_W-1:0]    request_bytes,
  input  ffba_pkg::off_t                payload_offset,
  input  ffba_pkg::hdr_t                rd_data,
  output ffba_pkg::mem_req_t            mem_req,
  output logic                          res_valid,
  input  logic                          res_take,
  output ffba_pkg::status_t             res_status,
  output ffba_pkg::off_t                res_offset
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_MARK = 5'b00100,
    S_FREE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state, state_next;
  ffba_pkg::pos_t    pos, pos_next;
  ffba_pkg::need_t   need, need_next;
  ffba_pkg::pos_t    keep_size, keep_size_next;
  ffba_pkg::status_t res_status_next;
  ffba_pkg::off_t    res_offset_next;

  ffba_pkg::need_t   need_in;
  ffba_pkg::cmp_t    hdr_pos;
  ffba_pkg::cmp_t    split_pos;
  ffba_pkg::cmp_t    step;
  ffba_pkg::pos_t    remain;
  logic              fits;
  logic              can_split;

  always_comb begin
    need_in = (ffba_pkg::need_t'(request_bytes)
               + ffba_pkg::need_t'(ffba_pkg::ALIGN_BYTES - 1))
              & ~ffba_pkg::need_t'(ffba_pkg::ALIGN_BYTES - 1);
    hdr_pos   = ffba_pkg::cmp_t'(payload_offset) - ffba_pkg::cmp_t'(ffba_pkg::HEADER_BYTES);
    split_pos = ffba_pkg::cmp_t'(pos) + ffba_pkg::cmp_t'(ffba_pkg::HEADER_BYTES)
                + ffba_pkg::cmp_t'(need);
    step      = ffba_pkg::cmp_t'(pos) + ffba_pkg::cmp_t'(ffba_pkg::HEADER_BYTES)
                + ffba_pkg::cmp_t'(rd_data.size);
    remain    = rd_data.size - ffba_pkg::pos_t'(need)
                - ffba_pkg::pos_t'(ffba_pkg::HEADER_BYTES);
    fits      = rd_data.free_mark
                && (ffba_pkg::cmp_t'(rd_data.size) >= ffba_pkg::cmp_t'(need));
    can_split = (ffba_pkg::cmp_t'(rd_data.size) >= ffba_pkg::cmp_t'(need)
                 + ffba_pkg::cmp_t'(ffba_pkg::HEADER_BYTES + ffba_pkg::ALIGN_BYTES))
                && (split_pos < ffba_pkg::cmp_t'(ffba_pkg::HEAP_BYTES));
  end

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    need_next       = need;
    keep_size_next  = keep_size;
    res_status_next = res_status;
    res_offset_next = res_offset;
    mem_req         = '0;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          res_offset_next = '0;
          if (op == ffba_pkg::OP_ALLOC) begin
            if (request_bytes == '0) begin
              res_status_next = ffba_pkg::ST_IGNORED;
              state_next      = S_DONE;
            end else begin
              need_next      = need_in;
              pos_next       = '0;
              mem_req.rd_en  = 1'b1;
              mem_req.rd_idx = '0;
              state_next     = S_WALK;
            end
          end else if ((ffba_pkg::cmp_t'(payload_offset)
                        < ffba_pkg::cmp_t'(ffba_pkg::HEADER_BYTES))
                       || (hdr_pos >= ffba_pkg::cmp_t'(ffba_pkg::HEAP_BYTES))) begin
            res_status_next = ffba_pkg::ST_IGNORED;
            state_next      = S_DONE;
          end else if (hdr_pos[ffba_pkg::GRAIN_SH-1:0] != '0) begin
            res_status_next = ffba_pkg::ST_FREED;
            state_next      = S_DONE;
          end else begin
            pos_next       = hdr_pos[ffba_pkg::POS_W-1:0];
            mem_req.rd_en  = 1'b1;
            mem_req.rd_idx = hdr_pos[ffba_pkg::POS_W-1:ffba_pkg::GRAIN_SH];
            state_next     = S_FREE;
          end
        end
      end
      S_WALK: begin
        if (fits) begin
          if (can_split) begin
            keep_size_next            = ffba_pkg::pos_t'(need);
            mem_req.wr_en             = 1'b1;
            mem_req.wr_idx            = split_pos[ffba_pkg::POS_W-1:ffba_pkg::GRAIN_SH];
            mem_req.wr_data.free_mark = 1'b1;
            mem_req.wr_data.size      = remain;
          end else begin
            keep_size_next = rd_data.size;
          end
          state_next = S_MARK;
        end else if (step >= ffba_pkg::cmp_t'(ffba_pkg::HEAP_BYTES)) begin
          res_status_next = ffba_pkg::ST_NOMEM;
          state_next      = S_DONE;
        end else begin
          pos_next       = step[ffba_pkg::POS_W-1:0];
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = step[ffba_pkg::POS_W-1:ffba_pkg::GRAIN_SH];
        end
      end
      S_MARK: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_idx            = pos[ffba_pkg::POS_W-1:ffba_pkg::GRAIN_SH];
        mem_req.wr_data.free_mark = 1'b0;
        mem_req.wr_data.size      = keep_size;
        res_status_next           = ffba_pkg::ST_ALLOC;
        res_offset_next           = ffba_pkg::off_t'(ffba_pkg::cmp_t'(pos)
                                      + ffba_pkg::cmp_t'(ffba_pkg::HEADER_BYTES));
        state_next                = S_DONE;
      end
      S_FREE: begin
        mem_req.wr_en             = 1'b1;
        mem_req.wr_idx            = pos[ffba_pkg::POS_W-1:ffba_pkg::GRAIN_SH];
        mem_req.wr_data.free_mark = 1'b1;
        mem_req.wr_data.size      = rd_data.size;
        res_status_next           = ffba_pkg::ST_FREED;
        state_next                = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    need       <= need_next;
    keep_size  <= keep_size_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
  end

endmodule

// ===== sv/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with block splitting and no coalescing.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tuser operation, tdata bytes/offset
//   m_axis   out  m_axis_tvalid/m_axis_tready   tuser status, tdata granted offset
//
// Allocate: the walk reads one block header per cycle (up to 256), then
// splits the block where it can and marks it, or reports no memory.
// A free of an aligned offset reads its header and sets the free mark;
// ignored requests go straight to the result. Reset restores a single
// free block at once. A stalled result holds in the output register; a
// new request is taken while it waits, and the next result waits for the register to drain.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  input  logic [31:0] s_axis_tdata,   // [15:0] request_bytes, [28:16] payload_offset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic [15:0] m_axis_tdata    // [12:0] granted_offset
);

  ffba_pkg::mem_req_t mem_req;
  ffba_pkg::hdr_t     rd_data;
  ffba_pkg::status_t  res_status;
  ffba_pkg::off_t     res_offset;
  logic               res_valid;
  logic               res_take;

  assign res_take = !m_axis_tvalid || m_axis_tready;

  ffba_walk u_walk (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (s_axis_tvalid),
    .req_ready      (s_axis_tready),
    .op             (s_axis_tuser[0]),
    .request_bytes  (s_axis_tdata[15:0]),
    .payload_offset (s_axis_tdata[28:16]),
    .rd_data        (rd_data),
    .mem_req        (mem_req),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res_status     (res_status),
    .res_offset     (res_offset)
  );

  ffba_hdr_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {3'b000, res_offset};
    end
  end

endmodule

// ===== sv/ffba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [1:0]  m_axis_tuser,
  input logic [15:0] m_axis_tdata
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a request is in progress");

  a_no_offset_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ffba_pkg::ST_ALLOC) |-> (m_axis_tdata == '0))
    else $error("offset given without allocation");

  a_grant_past_header: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ffba_pkg::ST_ALLOC)
      |-> (m_axis_tdata[12:0] >= 13'(ffba_pkg::HEADER_BYTES)))
    else $error("granted offset overlaps first header");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
